// File: rtl/core/sma_pkg.sv
// Shared types and constants for the seven-channel moving average.
package sma_pkg;

  localparam int NumChan = 7;
  localparam int DataW   = 16;
  localparam int HeldW   = 5;
  localparam int ChanW   = 3;

  // Channel order inside a sample vector
  localparam logic [ChanW-1:0] CH_ACCEL_X = 3'd0;
  localparam logic [ChanW-1:0] CH_ACCEL_Y = 3'd1;
  localparam logic [ChanW-1:0] CH_ACCEL_Z = 3'd2;
  localparam logic [ChanW-1:0] CH_RATE_X  = 3'd3;
  localparam logic [ChanW-1:0] CH_RATE_Y  = 3'd4;
  localparam logic [ChanW-1:0] CH_RATE_Z  = 3'd5;
  localparam logic [ChanW-1:0] CH_TEMP    = 3'd6;

  // One sample of all channels
  typedef logic [NumChan-1:0][DataW-1:0] sample_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic    valid;
    sample_t data;
  } q_head_t;

endpackage

// File: rtl/core/sma_front.sv
// Front end: accepts sample items into a two-entry queue.
module sma_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  sma_pkg::sample_t in_data_i,
  output sma_pkg::q_head_t head_o,
  input  logic             pop_i
);
  import sma_pkg::*;

  sample_t    entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign pop        = pop_i && (cnt_q != 2'd0);

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage, payload only
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= in_data_i;
    end
  end

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.data  = entry_q[rd_ptr_q];

endmodule

// File: rtl/core/sma_div.sv
// Serial restoring divider: signed sum by unsigned count, one bit per cycle.
module sma_div #(
  parameter int SumW = 21,
  parameter int CntW = 5
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [SumW-1:0] dividend_i,
  input  logic [CntW-1:0]        divisor_i,
  output logic                   done_o,
  output logic [sma_pkg::DataW-1:0] quot_o
);
  import sma_pkg::*;

  localparam int StepW = $clog2(SumW + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [StepW-1:0] step_q, step_d;
  logic             neg_q, neg_d;
  logic [SumW-1:0]  quo_q, quo_d;
  logic [CntW-1:0]  rem_q, rem_d;
  logic [CntW:0]    rem_sh, rem_diff;
  logic             ge;
  logic [SumW-1:0]  quo_signed;

  // One restoring step
  assign rem_sh   = {rem_q, quo_q[SumW-1]};
  assign rem_diff = rem_sh - {1'b0, divisor_i};
  assign ge       = (rem_sh >= {1'b0, divisor_i});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    neg_d  = neg_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = StepW'(SumW);
      neg_d  = dividend_i[SumW-1];
      quo_d  = dividend_i[SumW-1] ? SumW'(-dividend_i) : SumW'(dividend_i);
      rem_d  = '0;
    end else if (busy_q) begin
      quo_d  = {quo_q[SumW-2:0], ge};
      rem_d  = ge ? rem_diff[CntW-1:0] : rem_sh[CntW-1:0];
      step_d = step_q - StepW'(1);
      if (step_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  // Restore sign, truncate toward zero is implicit in magnitude division
  assign quo_signed = neg_q ? (~quo_q + SumW'(1)) : quo_q;
  assign quot_o     = quo_signed[DataW-1:0];
  assign done_o     = done_q;

endmodule

// File: rtl/core/sma_back.sv
// Back end: window store, running sums, serial averaging and result register.
module sma_back #(
  parameter int WINDOW_DEPTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sma_pkg::q_head_t head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output sma_pkg::sample_t avg_o,
  output logic [sma_pkg::HeldW-1:0] held_o
);
  import sma_pkg::*;

  localparam int CntW  = $clog2(WINDOW_DEPTH + 1);
  localparam int SlotW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int SumW  = 17 + $clog2(WINDOW_DEPTH);
  localparam logic [CntW-1:0]  DepthCnt = CntW'(WINDOW_DEPTH);
  localparam logic [SlotW-1:0] LastSlot = SlotW'(WINDOW_DEPTH - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_READ   = 3'd1;
  localparam logic [2:0] S_UPDATE = 3'd2;
  localparam logic [2:0] S_START  = 3'd3;
  localparam logic [2:0] S_WAIT   = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  logic [2:0]             state_q, state_d;
  logic [SlotW-1:0]       slot_q, slot_d;
  logic [CntW-1:0]        fill_q, fill_d;
  logic [ChanW-1:0]       chan_q, chan_d;
  logic signed [SumW-1:0] sums_q [NumChan];
  logic signed [SumW-1:0] sums_d [NumChan];
  sample_t                new_q;
  sample_t                old_q;
  sample_t                avg_q;
  sample_t                window_mem [WINDOW_DEPTH];
  logic                   full;
  logic                   div_start, div_done;
  logic [DataW-1:0]       div_quot;
  logic [CntW+HeldW-1:0]  held_ext;

  assign full = (fill_q == DepthCnt);

  // Sequencer
  always_comb begin
    state_d   = state_q;
    slot_d    = slot_q;
    fill_d    = fill_q;
    chan_d    = chan_q;
    pop_o     = 1'b0;
    div_start = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (head_i.valid) begin
          pop_o   = 1'b1;
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_UPDATE;
      end
      S_UPDATE: begin
        if (!full) begin
          fill_d = fill_q + CntW'(1);
        end
        slot_d  = (slot_q == LastSlot) ? '0 : slot_q + SlotW'(1);
        chan_d  = CH_ACCEL_X;
        state_d = S_START;
      end
      S_START: begin
        div_start = 1'b1;
        state_d   = S_WAIT;
      end
      S_WAIT: begin
        if (div_done) begin
          if (chan_q == CH_TEMP) begin
            state_d = S_OUT;
          end else begin
            chan_d  = chan_q + ChanW'(1);
            state_d = S_START;
          end
        end
      end
      S_OUT: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Per-channel sum update: drop the oldest entry once full, add the new one
  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      sums_d[c] = sums_q[c];
      if (state_q == S_UPDATE) begin
        sums_d[c] = sums_q[c] + SumW'($signed(new_q[c]))
                    - (full ? SumW'($signed(old_q[c])) : SumW'(0));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      slot_q  <= '0;
      fill_q  <= '0;
      chan_q  <= '0;
      for (int c = 0; c < NumChan; c++) begin
        sums_q[c] <= '0;
      end
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
      fill_q  <= fill_d;
      chan_q  <= chan_d;
      for (int c = 0; c < NumChan; c++) begin
        sums_q[c] <= sums_d[c];
      end
    end
  end

  // Sample capture, window memory and averages (payload only)
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      new_q <= head_i.data;
    end
    if (state_q == S_READ) begin
      old_q <= window_mem[slot_q];
    end
    if (state_q == S_UPDATE) begin
      window_mem[slot_q] <= new_q;
    end
    if ((state_q == S_WAIT) && div_done) begin
      avg_q[chan_q] <= div_quot;
    end
  end

  sma_div #(
    .SumW (SumW),
    .CntW (CntW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sums_q[chan_q]),
    .divisor_i  (fill_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Fill count reported in five bits
  assign held_ext    = {{HeldW{1'b0}}, fill_q};
  assign held_o      = held_ext[HeldW-1:0];
  assign avg_o       = avg_q;
  assign out_valid_o = (state_q == S_OUT);

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= DepthCnt)
    else $error("fill count above window depth");

  a_slot_tracks_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !full |-> (CntW'(slot_q) == fill_q))
    else $error("write slot out of step with fill count while filling");

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_WAIT))
    else $error("divider finished outside of wait state");

  a_no_zero_divide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> (fill_q != '0))
    else $error("division started with empty window");
`endif

endmodule

// File: rtl/core/seven_channel_moving_average.sv
// Sequence: each accepted item updates the running sums, then the shared serial
//   divider averages the seven channels one after another on SUM_W-bit sums, where
//   SUM_W is 17+clog2(WINDOW_DEPTH).
// Flow: the back end takes the next item only once the result has been accepted;
//   a two-entry input queue takes new items while a result waits on the output.
// Reset: asynchronous, active low; clears sums, write slot and fill count.
module seven_channel_moving_average #(
  parameter int WINDOW_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] accel_x_in_i,
  input  logic [15:0] accel_y_in_i,
  input  logic [15:0] accel_z_in_i,
  input  logic [15:0] rate_x_in_i,
  input  logic [15:0] rate_y_in_i,
  input  logic [15:0] rate_z_in_i,
  input  logic [15:0] temperature_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] accel_x_avg_o,
  output logic [15:0] accel_y_avg_o,
  output logic [15:0] accel_z_avg_o,
  output logic [15:0] rate_x_avg_o,
  output logic [15:0] rate_y_avg_o,
  output logic [15:0] rate_z_avg_o,
  output logic [15:0] temperature_avg_o,
  output logic [4:0]  samples_held_o
);
  import sma_pkg::*;

  sample_t in_sample;
  sample_t avg;
  q_head_t head;
  logic    pop;

  // Pack input channels
  always_comb begin
    in_sample             = '0;
    in_sample[CH_ACCEL_X] = accel_x_in_i;
    in_sample[CH_ACCEL_Y] = accel_y_in_i;
    in_sample[CH_ACCEL_Z] = accel_z_in_i;
    in_sample[CH_RATE_X]  = rate_x_in_i;
    in_sample[CH_RATE_Y]  = rate_y_in_i;
    in_sample[CH_RATE_Z]  = rate_z_in_i;
    in_sample[CH_TEMP]    = temperature_in_i;
  end

  sma_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_sample),
    .head_o     (head),
    .pop_i      (pop)
  );

  sma_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .avg_o       (avg),
    .held_o      (samples_held_o)
  );

  // Unpack averages
  assign accel_x_avg_o     = avg[CH_ACCEL_X];
  assign accel_y_avg_o     = avg[CH_ACCEL_Y];
  assign accel_z_avg_o     = avg[CH_ACCEL_Z];
  assign rate_x_avg_o      = avg[CH_RATE_X];
  assign rate_y_avg_o      = avg[CH_RATE_Y];
  assign rate_z_avg_o      = avg[CH_RATE_Z];
  assign temperature_avg_o = avg[CH_TEMP];

endmodule

// File: tb/sv/tb.sv
// Testbench for seven_channel_moving_average: window predictor, randomized driver and monitor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sma_pkg::*;

  localparam int WINDOW_DEPTH = 16;
  localparam int CYCLE_LIMIT  = 1500000;
  localparam int RAND_PER_PHASE = 350;
  localparam int NUM_PHASES   = 4;
  localparam int DRAIN_CYCLES = 300;
  localparam int REPORT_MAX   = 10;

  localparam logic [DataW-1:0] POS_MAX = 16'h7FFF;
  localparam logic [DataW-1:0] NEG_MAX = 16'h8000;

  // Expected result: one mean per channel plus the window fill
  typedef struct {
    sample_t          avg;
    logic [HeldW-1:0] held;
  } mean_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic             in_valid  = 1'b0;
  logic             in_ready_o;
  sample_t          in_sample = '0;
  logic             out_valid_o;
  logic             out_ready = 1'b0;
  sample_t          avg_out;
  logic [HeldW-1:0] held_out;

  // Stimulus and expectation stores
  sample_t pending_q[$];
  mean_t   mean_q[$];

  // Predictor state
  sample_t win_mem [WINDOW_DEPTH];
  longint  chan_sum [NumChan];
  int      wr_slot;
  int      held_count;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int err_count      = 0;
  int cycle_cnt      = 0;

  string chan_name [NumChan] = '{"accel_x", "accel_y", "accel_z",
                                 "rate_x", "rate_y", "rate_z", "temperature"};

  seven_channel_moving_average #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready_o),
    .accel_x_in_i     (in_sample[CH_ACCEL_X]),
    .accel_y_in_i     (in_sample[CH_ACCEL_Y]),
    .accel_z_in_i     (in_sample[CH_ACCEL_Z]),
    .rate_x_in_i      (in_sample[CH_RATE_X]),
    .rate_y_in_i      (in_sample[CH_RATE_Y]),
    .rate_z_in_i      (in_sample[CH_RATE_Z]),
    .temperature_in_i (in_sample[CH_TEMP]),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready),
    .accel_x_avg_o    (avg_out[CH_ACCEL_X]),
    .accel_y_avg_o    (avg_out[CH_ACCEL_Y]),
    .accel_z_avg_o    (avg_out[CH_ACCEL_Z]),
    .rate_x_avg_o     (avg_out[CH_RATE_X]),
    .rate_y_avg_o     (avg_out[CH_RATE_Y]),
    .rate_z_avg_o     (avg_out[CH_RATE_Z]),
    .temperature_avg_o(avg_out[CH_TEMP]),
    .samples_held_o   (held_out)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Push one sample into the window and return the new means
  function automatic mean_t advance_window(sample_t s);
    mean_t r;
    bit    full;
    full = (held_count >= WINDOW_DEPTH);
    for (int c = 0; c < NumChan; c++) begin
      if (full) chan_sum[c] -= longint'($signed(win_mem[wr_slot][c]));
      win_mem[wr_slot][c] = s[c];
      chan_sum[c] += longint'($signed(s[c]));
    end
    if (!full) held_count++;
    wr_slot = (wr_slot + 1) % WINDOW_DEPTH;
    // signed division truncates toward zero
    for (int c = 0; c < NumChan; c++) begin
      r.avg[c] = DataW'(chan_sum[c] / longint'(held_count));
    end
    r.held = HeldW'(held_count);
    return r;
  endfunction

  task automatic flag_error(string msg);
    err_count++;
    if (err_count <= REPORT_MAX) $display("mismatch: %s", msg);
  endtask

  function automatic logic [DataW-1:0] small_val();
    return DataW'(int'($urandom_range(8)) - 4);
  endfunction

  // Driver: predicts on accept, then presents the next item or idles
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready_o) mean_q.push_back(advance_window(in_sample));
      if (!in_valid || in_ready_o) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_sample <= pending_q.pop_front();
          in_valid  <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result against the oldest expectation
  always @(posedge clk_i) begin
    mean_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready) begin
        if (mean_q.size() == 0) begin
          flag_error("result with no item pending");
        end else begin
          want = mean_q.pop_front();
          for (int c = 0; c < NumChan; c++) begin
            if (avg_out[c] !== want.avg[c])
              flag_error($sformatf("%s_avg expected %0d got %0d", chan_name[c],
                                   $signed(want.avg[c]), $signed(avg_out[c])));
          end
          if (held_out !== want.held)
            flag_error($sformatf("samples_held expected %0d got %0d",
                                 want.held, held_out));
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Run guard
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("[seven_channel_moving_average] ERROR");
      $finish;
    end
  end

  initial begin
    sample_t s;
    sample_t pat;
    int      n;
    int      run_len;
    int      kind;

    for (int k = 0; k < WINDOW_DEPTH; k++) win_mem[k] = '0;
    for (int c = 0; c < NumChan; c++) chan_sum[c] = 0;
    wr_slot    = 0;
    held_count = 0;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: fill with opposite extremes per channel, wrap with the
    // inverse pattern, then small values for truncation of negative sums
    for (int k = 0; k < WINDOW_DEPTH; k++) begin
      for (int c = 0; c < NumChan; c++) s[c] = (c % 2 == 0) ? POS_MAX : NEG_MAX;
      pending_q.push_back(s);
    end
    for (int k = 0; k < 8; k++) begin
      for (int c = 0; c < NumChan; c++) s[c] = (c % 2 == 0) ? NEG_MAX : POS_MAX;
      pending_q.push_back(s);
    end
    for (int c = 0; c < NumChan; c++) s[c] = DataW'(c - 3);
    pending_q.push_back(s);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      @(negedge clk_i);
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase

      n = 0;
      while (n < RAND_PER_PHASE) begin
        kind = $urandom_range(99);
        if (kind < 15) begin
          // run of extremes long enough to fill the window
          for (int c = 0; c < NumChan; c++) pat[c] = $urandom_range(1) ? POS_MAX : NEG_MAX;
          run_len = $urandom_range(WINDOW_DEPTH + 4, WINDOW_DEPTH);
          for (int k = 0; k < run_len; k++) pending_q.push_back(pat);
          n += run_len;
        end else if (kind < 35) begin
          // small values around zero
          run_len = $urandom_range(20, 1);
          for (int k = 0; k < run_len; k++) begin
            for (int c = 0; c < NumChan; c++) s[c] = small_val();
            pending_q.push_back(s);
          end
          n += run_len;
        end else begin
          for (int c = 0; c < NumChan; c++) s[c] = DataW'($urandom_range(16'hFFFF));
          pending_q.push_back(s);
          n++;
        end
      end

      // phase ends once every item has been accepted and answered
      while (pending_q.size() != 0 || in_valid || mean_q.size() != 0) @(negedge clk_i);
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0 && mean_q.size() == 0) begin
      $display("[seven_channel_moving_average] OK");
    end else begin
      $display("[seven_channel_moving_average] ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/sma_pkg.sv
rtl/core/sma_front.sv
rtl/core/sma_div.sv
rtl/core/sma_back.sv
rtl/core/seven_channel_moving_average.sv
tb/sv/tb.sv
